/* hdl/interrupt_controller_halt_core_assert.svh */
// assertion macros for the interrupt controller core
`ifndef INTERRUPT_CONTROLLER_HALT_CORE_ASSERT_SVH
`define INTERRUPT_CONTROLLER_HALT_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// check a property on every clock edge outside reset
`define ICH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("interrupt controller assertion failed");

// check a property on every clock edge, reset included
`define ICH_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("interrupt controller assertion failed");

`else

`define ICH_ASSERT(label, clk, rst_n, prop)
`define ICH_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

/* hdl/ich_pkg.sv */
`default_nettype none

package ich_pkg;

    // default number of interrupt lines, and the flag register reset value
    localparam int          LINE_COUNT_DEF = 5;
    localparam logic [7:0]  FLAG_RESET     = 8'hE0;

    // item opcodes
    typedef enum logic [2:0] {
        OP_RAISE     = 3'd0,
        OP_ENABLE    = 3'd1,
        OP_DISABLE   = 3'd2,
        OP_HALT      = 3'd3,
        OP_CLR_KIND  = 3'd4,
        OP_SERVICE   = 3'd5,
        OP_WR_FLAGS  = 3'd6,
        OP_WR_ENABLE = 3'd7
    } t_opcode;

    // halt kinds
    typedef enum logic [1:0] {
        KIND_IME  = 2'd0,
        KIND_STOP = 2'd1,
        KIND_BUG  = 2'd2,
        KIND_NONE = 2'd3
    } t_halt_kind;

    // controller state
    typedef struct packed {
        logic [7:0] flags;
        logic [7:0] enable;
        logic       master_enable;
        t_halt_kind halt_kind;
        logic       halted;
    } t_state;

    // one input item
    typedef struct packed {
        t_opcode    opcode;
        logic [2:0] line_index;
        logic [7:0] write_data;
    } t_item;

    // one result item
    typedef struct packed {
        logic       halt_stops_cpu;
        logic       wake;
        logic       extra_tick;
        logic       dispatch;
        logic [2:0] vector_index;
        logic       master_enable_now;
        logic [7:0] flags_now;
        logic [7:0] enable_now;
    } t_result;

endpackage

`default_nettype wire

/* hdl/interrupt_controller_halt_core.sv */
// Interrupt controller with halt handling for a small handheld cpu core.
// Each input item carries one opcode (raise line, set or clear master
// enable, halt, clear halt kind, service, write flags, write enable) and
// produces exactly one result item with the halt, wake and dispatch
// outcome plus the register values after the item. An item goes through an
// input register, one pass of bit logic that also updates the state, and
// an output register. A new item is taken every
// cycle, so throughput is one item per cycle while the output side takes
// results. After reset the flag register reads 0xE0, everything else is
// clear and no halt is in effect.
`default_nettype none

module interrupt_controller_halt_core import ich_pkg::*; #(
    parameter int LINE_COUNT = LINE_COUNT_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [2:0] i_opcode,
    input  wire logic [2:0] i_line_index,
    input  wire logic [7:0] i_write_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_halt_stops_cpu,
    output logic            o_wake,
    output logic            o_extra_tick,
    output logic            o_dispatch,
    output logic [2:0]      o_vector_index,
    output logic            o_master_enable_now,
    output logic [7:0]      o_flags_now,
    output logic [7:0]      o_enable_now
);

`include "interrupt_controller_halt_core_assert.svh"

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_st;
    t_state  n_st;
    t_result n_out;
    logic    w_out_load;
    logic    w_step;

    // pipeline control: the output register loads when empty or being taken
    assign w_out_load = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_out_load;
    assign o_in_stall = r_in_valid && !w_out_load;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in.opcode     <= t_opcode'(i_opcode);
            r_in.line_index <= i_line_index;
            r_in.write_data <= i_write_data;
        end
    end

    // item logic
    ich_step #(
        .LINE_COUNT (LINE_COUNT)
    ) u_step (
        .i_state  (r_st),
        .i_item   (r_in),
        .o_state  (n_st),
        .o_result (n_out)
    );

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.flags         <= FLAG_RESET;
            r_st.enable        <= '0;
            r_st.master_enable <= 1'b0;
            r_st.halt_kind     <= KIND_NONE;
            r_st.halted        <= 1'b0;
        end else if (w_step) begin
            r_st <= n_st;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_halt_stops_cpu    = r_out.halt_stops_cpu;
    assign o_wake              = r_out.wake;
    assign o_extra_tick        = r_out.extra_tick;
    assign o_dispatch          = r_out.dispatch;
    assign o_vector_index      = r_out.vector_index;
    assign o_master_enable_now = r_out.master_enable_now;
    assign o_flags_now         = r_out.flags_now;
    assign o_enable_now        = r_out.enable_now;

    // a dispatch always leaves the master enable clear
    `ICH_ASSERT(a_disp_clears_me, i_clk, i_rst_n,
        r_out_valid && r_out.dispatch |-> !r_out.master_enable_now)

    // a stalled item stays in the input register
    `ICH_ASSERT(a_in_held, i_clk, i_rst_n,
        r_in_valid && o_in_stall |=> r_in_valid && $stable(r_in))

    // a wake leaves the cpu running with no halt kind
    `ICH_ASSERT(a_wake_clears_halt, i_clk, i_rst_n,
        w_step && n_out.wake |=> !r_st.halted && r_st.halt_kind == KIND_NONE)

    // a result that waits is not overwritten
    `ICH_ASSERT(a_out_held, i_clk, i_rst_n,
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out))

    // the vector index is zero without a dispatch
    `ICH_ASSERT(a_vec_zero, i_clk, i_rst_n,
        r_out_valid && !r_out.dispatch |-> r_out.vector_index == 3'd0)

endmodule

`default_nettype wire

/* hdl/ich_step.sv */
`default_nettype none

module ich_step import ich_pkg::*; #(
    parameter int LINE_COUNT = LINE_COUNT_DEF
) (
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    logic [7:0] w_mask;
    logic [7:0] w_pend;
    logic [2:0] w_low;
    logic       w_line_ok;

    // lines at and above the line count never count as pending
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_mask[i] = (i < LINE_COUNT);
        end
    end

    assign w_pend    = i_state.flags & i_state.enable & w_mask;
    assign w_line_ok = ({1'b0, i_item.line_index} < 4'(LINE_COUNT));

    // lowest pending line
    always_comb begin
        w_low = '0;
        for (int i = LINE_COUNT - 1; i >= 0; i--) begin
            if (w_pend[i]) begin
                w_low = 3'(i);
            end
        end
    end

    // next state and result for one item
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_item.opcode)
            OP_RAISE: begin
                if (w_line_ok) begin
                    o_state.flags = i_state.flags | (8'b1 << i_item.line_index);
                end
            end
            OP_ENABLE: begin
                o_state.master_enable = 1'b1;
            end
            OP_DISABLE: begin
                o_state.master_enable = 1'b0;
            end
            OP_HALT: begin
                if (i_state.master_enable) begin
                    o_state.halt_kind = KIND_IME;
                end else if (w_pend == '0) begin
                    o_state.halt_kind = KIND_STOP;
                end else begin
                    o_state.halt_kind = KIND_BUG;
                end
                o_result.halt_stops_cpu = (o_state.halt_kind != KIND_BUG);
                o_state.halted          = (o_state.halt_kind != KIND_BUG);
            end
            OP_CLR_KIND: begin
                o_state.halt_kind = KIND_NONE;
            end
            OP_SERVICE: begin
                if (i_state.halt_kind != KIND_BUG && w_pend != '0) begin
                    // wake a halted cpu
                    if (i_state.halted) begin
                        o_state.halted      = 1'b0;
                        o_state.halt_kind   = KIND_NONE;
                        o_result.wake       = 1'b1;
                        o_result.extra_tick = !i_state.master_enable;
                    end
                    // hand the lowest pending line to the cpu
                    if (i_state.master_enable) begin
                        o_result.dispatch     = 1'b1;
                        o_result.vector_index = w_low;
                        o_state.flags         = i_state.flags & ~(8'b1 << w_low);
                        o_state.master_enable = 1'b0;
                    end
                end
            end
            OP_WR_FLAGS: begin
                o_state.flags = i_item.write_data;
            end
            OP_WR_ENABLE: begin
                o_state.enable = i_item.write_data;
            end
            default: begin
                o_state = i_state;
            end
        endcase
        o_result.master_enable_now = o_state.master_enable;
        o_result.flags_now         = o_state.flags;
        o_result.enable_now        = o_state.enable;
    end

endmodule

`default_nettype wire

/* sim/interrupt_controller_halt_checker.sv */
`timescale 1ns / 1ps

module interrupt_controller_halt_checker import ich_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic [2:0] i_opcode,
    input  wire logic [2:0] i_line_index,
    input  wire logic [7:0] i_write_data,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic       i_halt_stops_cpu,
    input  wire logic       i_wake,
    input  wire logic       i_extra_tick,
    input  wire logic       i_dispatch,
    input  wire logic [2:0] i_vector_index,
    input  wire logic       i_master_enable_now,
    input  wire logic [7:0] i_flags_now,
    input  wire logic [7:0] i_enable_now,
    output int              o_fail_count,
    output int              o_outstanding
);

    localparam logic [7:0] LINE_MASK = 8'((1 << LINE_COUNT_DEF) - 1);

    // controller state as predicted
    logic [7:0] flag_bits;
    logic [7:0] enable_bits;
    logic       ime;
    t_halt_kind kind;
    logic       halted;

    // results still owed by the block, oldest first
    t_result    owed_results[$];

    // lines that are flagged, enabled and inside the line count
    function automatic logic [7:0] live_lines();
        return flag_bits & enable_bits & LINE_MASK;
    endfunction

    // apply one item to the predicted state and return its result
    function automatic t_result apply_item(input t_item it);
        t_result    r;
        logic [7:0] live;
        r = '0;
        live = live_lines();
        case (it.opcode)
            OP_RAISE: begin
                if (it.line_index < LINE_COUNT_DEF)
                    flag_bits[it.line_index] = 1'b1;
            end
            OP_ENABLE:   ime = 1'b1;
            OP_DISABLE:  ime = 1'b0;
            OP_HALT: begin
                if (ime)
                    kind = KIND_IME;
                else if (live == 8'h00)
                    kind = KIND_STOP;
                else
                    kind = KIND_BUG;
                r.halt_stops_cpu = (kind != KIND_BUG);
                halted = r.halt_stops_cpu;
            end
            OP_CLR_KIND: kind = KIND_NONE;
            OP_SERVICE: begin
                // halt bug blocks service until the kind is cleared
                if (kind != KIND_BUG && live != 8'h00) begin
                    if (halted) begin
                        halted = 1'b0;
                        r.wake = 1'b1;
                        r.extra_tick = !ime;
                        kind = KIND_NONE;
                    end
                    // lowest pending line wins
                    if (ime) begin
                        for (int ln = 0; ln < LINE_COUNT_DEF; ln++) begin
                            if (!r.dispatch && live[ln]) begin
                                r.dispatch = 1'b1;
                                r.vector_index = 3'(ln);
                                flag_bits[ln] = 1'b0;
                                ime = 1'b0;
                            end
                        end
                    end
                end
            end
            OP_WR_FLAGS: flag_bits = it.write_data;
            default:     enable_bits = it.write_data;
        endcase
        r.master_enable_now = ime;
        r.flags_now = flag_bits;
        r.enable_now = enable_bits;
        return r;
    endfunction

    // watch both channels, predict on input and compare on output
    always @(posedge i_clk) begin
        t_item   item;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            flag_bits = FLAG_RESET;
            enable_bits = 8'h00;
            ime = 1'b0;
            kind = KIND_NONE;
            halted = 1'b0;
            owed_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                item.opcode = t_opcode'(i_opcode);
                item.line_index = i_line_index;
                item.write_data = i_write_data;
                owed_results.push_back(apply_item(item));
            end
            if (i_out_valid && !i_out_stall) begin
                got = {i_halt_stops_cpu, i_wake, i_extra_tick, i_dispatch, i_vector_index,
                       i_master_enable_now, i_flags_now, i_enable_now};
                if (owed_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result with nothing owed: %h", $realtime, got);
                end else begin
                    want = owed_results.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"%0t: mismatch stop/wake/tick/disp/vec/ime/flags/en ",
                                      "exp %b %b %b %b %0d %b %h %h got %b %b %b %b %0d %b %h %h"},
                                     $realtime,
                                     want.halt_stops_cpu, want.wake, want.extra_tick,
                                     want.dispatch, want.vector_index, want.master_enable_now,
                                     want.flags_now, want.enable_now,
                                     got.halt_stops_cpu, got.wake, got.extra_tick,
                                     got.dispatch, got.vector_index, got.master_enable_now,
                                     got.flags_now, got.enable_now);
                    end
                end
            end
        end
        o_outstanding = owed_results.size();
    end

endmodule

/* sim/interrupt_controller_halt_core_test.sv */
`timescale 1ns / 1ps

module interrupt_controller_halt_core_test;
    import ich_pkg::*;

    localparam int ITEM_TARGET = 850;
    localparam int HOLD_CYCLES = 60;
    localparam int STUCK_LIMIT = 1000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       out_stall;
    t_opcode    op_drv;
    logic [2:0] line_drv;
    logic [7:0] data_drv;

    wire logic       in_stall;
    wire logic       out_valid;
    wire logic       halt_stops_cpu;
    wire logic       wake;
    wire logic       extra_tick;
    wire logic       dispatch;
    wire logic [2:0] vector_index;
    wire logic       master_enable_now;
    wire logic [7:0] flags_now;
    wire logic [7:0] enable_now;

    int fail_count;
    int outstanding;
    int sent;
    int in_count;
    int hold_at;
    bit calm;

    interrupt_controller_halt_core i_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_opcode            (op_drv),
        .i_line_index        (line_drv),
        .i_write_data        (data_drv),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_halt_stops_cpu    (halt_stops_cpu),
        .o_wake              (wake),
        .o_extra_tick        (extra_tick),
        .o_dispatch          (dispatch),
        .o_vector_index      (vector_index),
        .o_master_enable_now (master_enable_now),
        .o_flags_now         (flags_now),
        .o_enable_now        (enable_now)
    );

    interrupt_controller_halt_checker i_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_stall          (in_stall),
        .i_opcode            (op_drv),
        .i_line_index        (line_drv),
        .i_write_data        (data_drv),
        .i_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .i_halt_stops_cpu    (halt_stops_cpu),
        .i_wake              (wake),
        .i_extra_tick        (extra_tick),
        .i_dispatch          (dispatch),
        .i_vector_index      (vector_index),
        .i_master_enable_now (master_enable_now),
        .i_flags_now         (flags_now),
        .i_enable_now        (enable_now),
        .o_fail_count        (fail_count),
        .o_outstanding       (outstanding)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // count accepted input items for the receiver's hold-off
    always @(posedge clk) begin
        if (!rst_n)
            in_count <= 0;
        else if (in_valid && !in_stall)
            in_count <= in_count + 1;
    end

    // result side: random stalls, plus long hold-offs that back the block up
    initial begin
        out_stall = 1'b0;
        hold_at = 40;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_at < 700 && in_count >= hold_at) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_at += 320;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < 6);
            end
        end
    end

    // cycles with nothing accepted on either side
    initial begin
        int idle_run;
        idle_run = 0;
        while (idle_run < STUCK_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // offer one item and hold it until taken; starts and ends at a falling edge
    task automatic send_item(input t_opcode op, input logic [2:0] ln, input logic [7:0] wd);
        while (!calm && $urandom_range(99) < 6) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op_drv <= op;
        line_drv <= ln;
        data_drv <= wd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // any opcode, mostly in-range lines
    task automatic send_random();
        int      pick;
        t_opcode op;
        pick = $urandom_range(99);
        if (pick < 18)
            op = OP_RAISE;
        else if (pick < 28)
            op = OP_ENABLE;
        else if (pick < 34)
            op = OP_DISABLE;
        else if (pick < 46)
            op = OP_HALT;
        else if (pick < 52)
            op = OP_CLR_KIND;
        else if (pick < 78)
            op = OP_SERVICE;
        else if (pick < 88)
            op = OP_WR_FLAGS;
        else
            op = OP_WR_ENABLE;
        send_item(op, ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4)),
                  8'($urandom_range(255)));
    endtask

    // enable some lines, halt, raise, then service: the usual wake path
    task automatic send_scenario();
        send_item(OP_WR_ENABLE, 3'($urandom_range(7)),
                  8'($urandom_range(255)) | 8'(1 << $urandom_range(4)));
        send_item($urandom_range(1) ? OP_ENABLE : OP_DISABLE, 3'($urandom_range(7)),
                  8'($urandom_range(255)));
        send_item(OP_HALT, 3'($urandom_range(7)), 8'($urandom_range(255)));
        if ($urandom_range(3) != 0)
            send_item(OP_RAISE, 3'($urandom_range(4)), 8'($urandom_range(255)));
        send_item(OP_SERVICE, 3'($urandom_range(7)), 8'($urandom_range(255)));
        if ($urandom_range(2) == 0)
            send_item(OP_CLR_KIND, 3'($urandom_range(7)), 8'($urandom_range(255)));
        send_item(OP_SERVICE, 3'($urandom_range(7)), 8'($urandom_range(255)));
    endtask

    // reset, directed items, random items, drain and verdict
    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op_drv = OP_RAISE;
        line_drv = 3'd0;
        data_drv = 8'h00;
        sent = 0;
        calm = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: halt kinds, wake, halt bug, dispatch order, range edges
        send_item(OP_WR_ENABLE, 3'd0, 8'hFF);
        send_item(OP_RAISE, 3'd7, 8'h00);      // line out of range
        send_item(OP_RAISE, 3'd5, 8'hFF);      // first line past the count
        send_item(OP_HALT, 3'd0, 8'h00);       // nothing pending, cpu stops
        send_item(OP_RAISE, 3'd4, 8'h00);
        send_item(OP_SERVICE, 3'd0, 8'h00);    // wake with extra tick
        send_item(OP_HALT, 3'd0, 8'h00);       // halt bug
        send_item(OP_ENABLE, 3'd0, 8'h00);
        send_item(OP_SERVICE, 3'd0, 8'h00);    // blocked by halt bug
        send_item(OP_CLR_KIND, 3'd0, 8'h00);
        send_item(OP_SERVICE, 3'd0, 8'h00);    // dispatch line 4
        send_item(OP_WR_FLAGS, 3'd7, 8'hFF);
        send_item(OP_ENABLE, 3'd0, 8'h00);
        send_item(OP_HALT, 3'd0, 8'h00);       // master enable set
        send_item(OP_SERVICE, 3'd0, 8'h00);    // wake and dispatch line 0
        send_item(OP_ENABLE, 3'd0, 8'h00);
        send_item(OP_SERVICE, 3'd0, 8'h00);    // dispatch line 1
        send_item(OP_DISABLE, 3'd0, 8'h00);
        send_item(OP_SERVICE, 3'd0, 8'h00);    // not halted, no master enable
        send_item(OP_WR_ENABLE, 3'd0, 8'hE0);  // only bits past the line count
        send_item(OP_ENABLE, 3'd0, 8'h00);
        send_item(OP_SERVICE, 3'd0, 8'h00);    // nothing pending
        send_item(OP_DISABLE, 3'd0, 8'h00);
        send_item(OP_HALT, 3'd0, 8'h00);       // high bits do not count as pending
        send_item(OP_WR_FLAGS, 3'd0, 8'h00);

        // random part, with a calm stretch in the middle
        while (sent < ITEM_TARGET) begin
            calm = (sent >= 300 && sent < 450);
            if ($urandom_range(99) < 45)
                send_scenario();
            else
                send_random();
        end
        in_valid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/ich_pkg.sv
hdl/ich_step.sv
hdl/interrupt_controller_halt_core.sv
sim/interrupt_controller_halt_checker.sv
sim/interrupt_controller_halt_core_test.sv
